// File: hw/rtl/pbsa_pkg.sv
// ----------------------------------------------------------------------------
// pbsa_pkg
// Shared codes, constants and the lowest-set-bit lookup for the slot allocator.
// ----------------------------------------------------------------------------
package pbsa_pkg;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } t_opcode;

    typedef enum logic {
        ST_OK   = 1'b0,
        ST_FAIL = 1'b1
    } t_status;

    localparam logic [31:0] C_DEBRUIJN_MUL   = 32'h05f6_6a47;
    localparam int unsigned C_DEBRUIJN_SHIFT = 27;
    localparam int unsigned C_SLOT_W         = 10;
    localparam int unsigned C_BIT_W          = 5;

    localparam logic [4:0] C_TZ_TABLE [32] = '{
        5'd0,  5'd1,  5'd2,  5'd26, 5'd23, 5'd3,  5'd15, 5'd27,
        5'd24, 5'd21, 5'd19, 5'd4,  5'd12, 5'd16, 5'd28, 5'd6,
        5'd31, 5'd25, 5'd22, 5'd14, 5'd20, 5'd18, 5'd11, 5'd5,
        5'd30, 5'd13, 5'd17, 5'd10, 5'd29, 5'd9,  5'd8,  5'd7
    };

    // Position of the lowest set bit: isolate it, multiply, take the top five bits.
    function automatic logic [4:0] lowest_bit_pos(input logic [31:0] w);
        logic [31:0] iso;
        logic [31:0] prod;
        iso  = w & (32'd0 - w);
        prod = iso * C_DEBRUIJN_MUL;
        return C_TZ_TABLE[prod[31:C_DEBRUIJN_SHIFT]];
    endfunction

endpackage

// File: hw/rtl/pbsa_if.sv
// ----------------------------------------------------------------------------
// pbsa_if
// Request and response channels of the slot allocator (valid/ready).
// ----------------------------------------------------------------------------
interface pbsa_req_if;
    logic       valid;
    logic       ready;
    logic       opcode;
    logic [1:0] level;
    logic [9:0] slot_index;

    modport source (output valid, opcode, level, slot_index, input ready);
    modport sink   (input valid, opcode, level, slot_index, output ready);
endinterface

interface pbsa_rsp_if;
    logic       valid;
    logic       ready;
    logic       status;
    logic [9:0] slot_out;
    logic       evicted;
    logic [1:0] evicted_level;

    modport source (output valid, status, slot_out, evicted, evicted_level, input ready);
    modport sink   (input valid, status, slot_out, evicted, evicted_level, output ready);
endinterface

// File: hw/rtl/priority_bitmap_slot_allocator_top.sv
// ----------------------------------------------------------------------------
// priority_bitmap_slot_allocator_top
// Slot allocator over per-level occupancy bitmaps kept in one block RAM.
// ----------------------------------------------------------------------------
// Usage:
//   i_req carries one request (allocate at a level, or free a slot); o_rsp
//   returns exactly one response per request. Both are valid/ready channels.
//   Requests are taken one at a time, in the idle state; the response sits in
//   an output register, so the next request is taken while it waits.
// Steps from request accept to response valid:
//   free     : one read-modify-write per level word.
//   allocate : scans the words of the levels below the target, one RAM read per
//              cycle; on a hit S_POS finds the bit, S_CLR clears it and S_SET
//              sets it in the target level; a scan that finds nothing fails.
//   failing requests (level 0, unknown level, slot out of range): straight to S_DONE.
// Scan rate: set by the RAM read port.
// Reset: a clearing pass writes every RAM word (level 0 all ones, other levels
//   zero); no request is taken until it finishes.
// Stall: if the output register still holds a response and o_rsp.ready stays
//   low, a finished request holds in S_DONE and no further request is accepted.
// ----------------------------------------------------------------------------
module priority_bitmap_slot_allocator_top
    import pbsa_pkg::*;
#(
    parameter int WORDS_PER_LEVEL = 32,
    parameter int NUM_LEVELS      = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pbsa_req_if.sink    i_req,
    pbsa_rsp_if.source  o_rsp
);

    localparam int DEPTH  = NUM_LEVELS * WORDS_PER_LEVEL;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int WORD_W = (WORDS_PER_LEVEL > 1) ? $clog2(WORDS_PER_LEVEL) : 1;
    localparam int LV_W   = $clog2(NUM_LEVELS);
    localparam int SLOTS  = WORDS_PER_LEVEL * 32;

    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_FREE  = 8'b0000_0100,
        S_SCAN  = 8'b0000_1000,
        S_POS   = 8'b0001_0000,
        S_CLR   = 8'b0010_0000,
        S_SET   = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } t_state;

    // bitmap RAM: entry = level * WORDS_PER_LEVEL + word
    logic [31:0]       mem [DEPTH];
    logic [31:0]       r_rdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [31:0]       mem_wdata;

    t_state            r_state;
    t_state            n_state;
    logic [ADDR_W-1:0] r_caddr;

    // request context
    logic [ADDR_W-1:0] r_lim;      // base of target level = number of words to scan
    logic [C_BIT_W-1:0] r_pos;
    logic [ADDR_W-1:0] r_addr;     // free walk address
    logic [LV_W-1:0]   r_lv;

    // scan issue and pending read
    logic [ADDR_W-1:0] r_raddr;
    logic [LV_W-1:0]   r_ilv;
    logic [WORD_W-1:0] r_iword;
    logic              r_pend;
    logic [ADDR_W-1:0] r_paddr;
    logic [LV_W-1:0]   r_plv;
    logic [WORD_W-1:0] r_pword;

    // found word
    logic [31:0]       r_found;
    logic [ADDR_W-1:0] r_faddr;
    logic [LV_W-1:0]   r_flv;
    logic [WORD_W-1:0] r_fword;

    // staged result
    logic              r_st;
    logic [9:0]        r_slot;
    logic              r_ev;
    logic [1:0]        r_evlv;

    // output register
    logic              r_out_valid;
    logic              r_out_status;
    logic [9:0]        r_out_slot;
    logic              r_out_ev;
    logic [1:0]        r_out_evlv;

    logic              req_acc;
    logic              req_free;
    logic              slot_ok;
    logic              level_ok;
    logic [WORD_W-1:0] req_word;
    logic              hit;
    logic              scan_end;
    logic              free_last;
    logic [31:0]       pos_bit;
    logic [ADDR_W-1:0] tgt_addr;
    logic              out_load;

    assign i_req.ready = (r_state == S_IDLE);
    assign req_acc     = i_req.valid && i_req.ready;
    assign req_free    = (i_req.opcode == OP_FREE);
    assign slot_ok     = (32'(i_req.slot_index) < 32'(SLOTS));
    assign level_ok    = (i_req.level != 2'd0) && (32'(i_req.level) < 32'(NUM_LEVELS));
    assign req_word    = WORD_W'(i_req.slot_index >> C_BIT_W);
    assign hit         = r_pend && (r_rdata != 32'd0);
    assign scan_end    = (r_raddr == r_lim);
    assign free_last   = (r_lv == LV_W'(NUM_LEVELS - 1));
    assign pos_bit     = 32'd1 << r_pos;
    assign tgt_addr    = ADDR_W'(r_lim + ADDR_W'(r_fword));
    assign out_load    = (r_state == S_DONE) && (!r_out_valid || o_rsp.ready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (r_caddr == ADDR_W'(DEPTH - 1)) n_state = S_IDLE;
            S_IDLE: begin
                if (req_acc) begin
                    if (req_free) n_state = slot_ok ? S_FREE : S_DONE;
                    else          n_state = level_ok ? S_SCAN : S_DONE;
                end
            end
            S_FREE:  if (free_last) n_state = S_DONE;
            S_SCAN: begin
                if (hit)           n_state = S_POS;
                else if (scan_end) n_state = S_DONE;
            end
            S_POS:   n_state = S_CLR;
            S_CLR:   n_state = S_SET;
            S_SET:   n_state = S_DONE;
            S_DONE:  if (out_load) n_state = S_IDLE;
            default: n_state = S_CLEAR;
        endcase
    end

    // RAM port control
    always_comb begin
        mem_re    = 1'b0;
        mem_raddr = r_raddr;
        mem_we    = 1'b0;
        mem_waddr = r_faddr;
        mem_wdata = r_found & ~pos_bit;
        unique case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_caddr;
                mem_wdata = (r_caddr < ADDR_W'(WORDS_PER_LEVEL)) ? '1 : '0;
            end
            S_IDLE: begin
                if (req_acc && req_free && slot_ok) begin
                    mem_re    = 1'b1;
                    mem_raddr = ADDR_W'(req_word);
                end
            end
            S_FREE: begin
                // set in level 0, clear elsewhere; fetch the next level meanwhile
                mem_we    = 1'b1;
                mem_waddr = r_addr;
                mem_wdata = (r_lv == '0) ? (r_rdata | pos_bit) : (r_rdata & ~pos_bit);
                if (!free_last) begin
                    mem_re    = 1'b1;
                    mem_raddr = ADDR_W'(r_addr + ADDR_W'(WORDS_PER_LEVEL));
                end
            end
            S_SCAN: begin
                if (!hit && !scan_end) begin
                    mem_re    = 1'b1;
                    mem_raddr = r_raddr;
                end
            end
            S_POS: begin
                mem_re    = 1'b1;
                mem_raddr = tgt_addr;
            end
            S_CLR: begin
                mem_we = 1'b1;
            end
            S_SET: begin
                mem_we    = 1'b1;
                mem_waddr = tgt_addr;
                mem_wdata = r_rdata | pos_bit;
            end
            S_DONE: ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_waddr] <= mem_wdata;
        if (mem_re) r_rdata <= mem[mem_raddr];
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_caddr     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) r_caddr <= ADDR_W'(r_caddr + 1'b1);
            if (out_load)           r_out_valid <= 1'b1;
            else if (o_rsp.ready)   r_out_valid <= 1'b0;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_lim   <= ADDR_W'(32'(i_req.level) * WORDS_PER_LEVEL);
                r_pos   <= i_req.slot_index[C_BIT_W-1:0];
                r_addr  <= ADDR_W'(req_word);
                r_lv    <= '0;
                r_raddr <= '0;
                r_ilv   <= '0;
                r_iword <= '0;
                r_pend  <= 1'b0;
                // defaults cover every failing request and a good free
                r_st    <= (req_free && slot_ok) ? ST_OK : ST_FAIL;
                r_slot  <= req_free ? i_req.slot_index : 10'd0;
                r_ev    <= 1'b0;
                r_evlv  <= 2'd0;
            end
            S_FREE: begin
                r_addr <= ADDR_W'(r_addr + ADDR_W'(WORDS_PER_LEVEL));
                r_lv   <= LV_W'(r_lv + 1'b1);
            end
            S_SCAN: begin
                if (hit) begin
                    r_found <= r_rdata;
                    r_faddr <= r_paddr;
                    r_flv   <= r_plv;
                    r_fword <= r_pword;
                end else if (!scan_end) begin
                    r_pend  <= 1'b1;
                    r_paddr <= r_raddr;
                    r_plv   <= r_ilv;
                    r_pword <= r_iword;
                    r_raddr <= ADDR_W'(r_raddr + 1'b1);
                    if (r_iword == WORD_W'(WORDS_PER_LEVEL - 1)) begin
                        r_iword <= '0;
                        r_ilv   <= LV_W'(r_ilv + 1'b1);
                    end else begin
                        r_iword <= WORD_W'(r_iword + 1'b1);
                    end
                end
            end
            S_POS: begin
                r_pos <= lowest_bit_pos(r_found);
            end
            S_SET: begin
                r_st   <= ST_OK;
                r_slot <= 10'({r_fword, r_pos});
                r_ev   <= (r_flv != '0);
                r_evlv <= 2'(r_flv);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_status <= r_st;
            r_out_slot   <= r_slot;
            r_out_ev     <= r_ev;
            r_out_evlv   <= r_evlv;
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.status        = r_out_status;
    assign o_rsp.slot_out      = r_out_slot;
    assign o_rsp.evicted       = r_out_ev;
    assign o_rsp.evicted_level = r_out_evlv;

endmodule
